// ===== hdl/circular_fifo_queue_unit_macros.svh =====
// Assertion macros for the circular FIFO queue unit.
// Included by the top level; no other dependencies.
`ifndef CIRCULAR_FIFO_QUEUE_UNIT_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CFQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cfq_pkg.sv =====
// Shared constants, codes, control structs and index helpers for the
// circular FIFO queue unit. No dependencies.
package cfq_pkg;

   // storage geometry
   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;

   // field widths
   localparam int OP_W     = 2;
   localparam int CAP_W    = 5;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SHOW   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] K_ACK     = 3'd0;
   localparam logic [KIND_W-1:0] K_REMOVED = 3'd1;
   localparam logic [KIND_W-1:0] K_FRONT   = 3'd2;
   localparam logic [KIND_W-1:0] K_ITEM    = 3'd3;
   localparam logic [KIND_W-1:0] K_REAR    = 3'd4;

   // controller -> datapath commands
   typedef struct packed {
      logic                req_ready;
      logic                ram_wr;
      logic                push;
      logic                rd_head;
      logic                rd_ptr;
      logic                pop;
      logic                start_walk;
      logic                step_walk;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_status;
      logic [KIND_W-1:0]   rsp_kind;
      logic                rsp_last;
   } cfq_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic            req_valid;
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            out_free;
      logic            walk_last;
   } cfq_sts_type;

   // clamp a written capacity into 1..DEPTH
   function automatic logic [CNT_W-1:0] eff_cap_f(input logic [CAP_W-1:0] c);
      logic [31:0] c32;
      c32 = 32'(c);
      if (c32 == 32'd0) c32 = 32'd1;
      if (c32 > 32'(DEPTH)) c32 = 32'(DEPTH);
      return CNT_W'(c32);
   endfunction

   // reduce a sum below twice the capacity into a slot index
   function automatic logic [PTR_W-1:0] wrap_f(input logic [SUM_W-1:0] s,
                                                input logic [CNT_W-1:0] c);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(c)) ? s - SUM_W'(c) : s;
      return r[PTR_W-1:0];
   endfunction

endpackage

// ===== hdl/cfq_channels.sv =====
// Valid/ready channel interfaces for request, response and capacity write.
// Depends on cfq_pkg for field widths.
interface cfq_req_if import cfq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, op, value, input ready);
   modport sink   (input valid, op, value, output ready);
endinterface

interface cfq_rsp_if import cfq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] data;
   logic                     last;
   modport source (output valid, status, kind, data, last, input ready);
   modport sink   (input valid, status, kind, data, last, output ready);
endinterface

interface cfq_csr_if import cfq_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;
   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

// ===== hdl/circular_fifo_queue_unit.sv =====
// Circular FIFO queue unit: a ring buffer of signed 32-bit values.
// Requests enter on req_bus (op, value); results leave on rsp_bus
// (status, kind, data, last); csr_bus writes the capacity in use.
// Insert stores value or answers full; remove answers the oldest value
// or empty; show answers empty, or the front index, each held value oldest first,
// then the rear index, with last set on the final beat of a request.
// One request is in work at a time. Insert is answered from the execute
// state after the accept. Remove reads the head entry from the RAM, whose
// data is registered, then answers. Show reads each held value in turn
// through the single read port of the entry RAM (address, then data).
// Results sit in an output register; a stalled receiver holds the beat
// and pauses the sequence, nothing is dropped. An unused op code is
// taken and gives no result.
// Reset (synchronous, active high) empties the queue and sets capacity
// to 16 (clamped to the storage depth); a capacity write also empties the
// queue but keeps the stored words. Capacity 0 acts as 1.
`include "circular_fifo_queue_unit_macros.svh"
module circular_fifo_queue_unit import cfq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cfq_req_if.sink   req_bus,
   cfq_rsp_if.source rsp_bus,
   cfq_csr_if.sink   csr_bus
);

   cfq_cmd_type cmd;
   cfq_sts_type sts;

   cfq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   cfq_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

   // checks on controller and datapath cooperation
   `CFQ_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load_rsp, sts.out_free, "response beat overwritten")
   `CFQ_ASSERT_SAME(a_write_not_full, clock, reset, cmd.ram_wr, !sts.full, "store written while full")
   `CFQ_ASSERT_SAME(a_full_empty, clock, reset, sts.full, !sts.empty, "queue both full and empty")
   `CFQ_ASSERT_NEXT(a_busy_after_take, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while busy")

endmodule

// ===== hdl/cfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // registered read, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cfq_ctrl.sv =====
// Sequencing state machine of the circular FIFO queue unit.
// Depends on cfq_pkg; drives commands into cfq_datapath.
module cfq_ctrl import cfq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfq_sts_type sts,
   output cfq_cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_POP      = 3'd2;
   localparam logic [2:0] S_WALK_RD  = 3'd3;
   localparam logic [2:0] S_WALK_OUT = 3'd4;
   localparam logic [2:0] S_REAR     = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.out_free) begin
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = sts.full ? ST_FULL : ST_OK;
                     cmd.rsp_kind   = K_ACK;
                     cmd.rsp_last   = 1'b1;
                     cmd.ram_wr     = !sts.full;
                     cmd.push       = !sts.full;
                     state_in       = S_IDLE;
                  end
               end
               OP_REMOVE, OP_SHOW: begin
                  if (sts.empty) begin
                     if (sts.out_free) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                        cmd.rsp_kind   = K_ACK;
                        cmd.rsp_last   = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end else if (sts.op == OP_REMOVE) begin
                     cmd.rd_head = 1'b1;
                     state_in    = S_POP;
                  end else if (sts.out_free) begin
                     // front index beat, then walk the held entries
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = ST_OK;
                     cmd.rsp_kind   = K_FRONT;
                     cmd.start_walk = 1'b1;
                     state_in       = S_WALK_RD;
                  end
               end
               default: state_in = S_IDLE;  // unused op: no result
            endcase
         end
         S_POP: begin
            if (sts.out_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_kind   = K_REMOVED;
               cmd.rsp_last   = 1'b1;
               cmd.pop        = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_WALK_RD: begin
            cmd.rd_ptr = 1'b1;
            state_in   = S_WALK_OUT;
         end
         S_WALK_OUT: begin
            if (sts.out_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_kind   = K_ITEM;
               cmd.step_walk  = 1'b1;
               state_in       = sts.walk_last ? S_REAR : S_WALK_RD;
            end
         end
         S_REAR: begin
            if (sts.out_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_kind   = K_REAR;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hdl/cfq_datapath.sv =====
// Queue pointers, entry storage, capacity register and response register.
// Depends on cfq_pkg, cfq_channels and cfq_ram; controlled by cfq_ctrl.
module cfq_datapath import cfq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cfq_req_if.sink      req_bus,
   cfq_rsp_if.source    rsp_bus,
   cfq_csr_if.sink      csr_bus,
   input  cfq_cmd_type  cmd,
   output cfq_sts_type  sts
);

   logic [CNT_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  left_ff;
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] value_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff;

   logic [PTR_W-1:0]  tail_idx;
   logic [PTR_W-1:0]  rear_idx;
   logic [PTR_W-1:0]  head_next;
   logic [PTR_W-1:0]  ptr_next;
   logic [PTR_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              req_take;
   logic              csr_take;

   assign req_take = req_bus.valid && cmd.req_ready;
   assign csr_take = csr_bus.valid;

   assign req_bus.ready = cmd.req_ready;
   assign csr_bus.ready = 1'b1;

   // slot arithmetic: every sum stays below twice the capacity (rear_idx only while not empty)
   assign tail_idx  = wrap_f(SUM_W'(head_ff) + SUM_W'(count_ff), cap_ff);
   assign rear_idx  = wrap_f(SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1), cap_ff);
   assign head_next = wrap_f(SUM_W'(head_ff) + SUM_W'(1), cap_ff);
   assign ptr_next  = wrap_f(SUM_W'(ptr_ff) + SUM_W'(1), cap_ff);
   assign rd_addr   = cmd.rd_head ? head_ff : ptr_ff;

   // capacity and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= eff_cap_f(CAP_RESET);
         head_ff  <= '0;
         count_ff <= '0;
      end else if (csr_take) begin
         cap_ff   <= eff_cap_f(csr_bus.capacity);
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         head_ff  <= head_next;
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // latched request and walk position
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_bus.op;
         value_ff <= req_bus.value;
      end
      if (cmd.start_walk) begin
         ptr_ff  <= head_ff;
         left_ff <= count_ff;
      end else if (cmd.step_walk) begin
         ptr_ff  <= ptr_next;
         left_ff <= left_ff - CNT_W'(1);
      end
   end

   cfq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (tail_idx),
      .wr_data (value_ff),
      .rd_en   (cmd.rd_head || cmd.rd_ptr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response data select
   always_comb begin
      case (cmd.rsp_kind)
         K_REMOVED, K_ITEM: rsp_data_in = rd_data;
         K_FRONT:           rsp_data_in = DATA_W'(head_ff);
         K_REAR:            rsp_data_in = DATA_W'(rear_idx);
         default:           rsp_data_in = '0;
      endcase
   end

   // output register: one beat held until taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_kind_ff   <= cmd.rsp_kind;
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.kind   = rsp_kind_ff;
   assign rsp_bus.data   = rsp_data_ff;
   assign rsp_bus.last   = rsp_last_ff;

   // status to the controller
   assign sts.req_valid = req_bus.valid;
   assign sts.op        = op_ff;
   assign sts.full      = (count_ff >= cap_ff);
   assign sts.empty     = (count_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign sts.walk_last = (left_ff == CNT_W'(1));

endmodule
